[src/kars_pkg.sv]
package kars_pkg;

  // fixed field widths
  localparam int KEYS     = 3;
  localparam int CODE_W   = 2;   // key code = key index + 1
  localparam int RANK_W   = 2;   // holds 0..KEYS
  localparam int TIME_W   = 16;
  localparam int CFG_W    = 15;
  localparam int CFG_IDX_W = 2;

  // operation codes
  typedef enum logic [1:0] {
    OP_SCAN  = 2'd0,
    OP_GET   = 2'd1,
    OP_FLUSH = 2'd2,
    OP_PUSH  = 2'd3
  } op_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_IVL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_HOLD = 2'd2;

  localparam logic [CFG_W-1:0] FIRST_DELAY_RST  = 15'd400;
  localparam logic [CFG_W-1:0] REPEAT_IVL_RST   = 15'd100;
  localparam logic [CFG_W-1:0] RELEASE_HOLD_RST = 15'd50;

  typedef struct packed {
    op_t               op;
    logic [KEYS-1:0]   key_levels;
    logic [TIME_W-1:0] now_ms;
    logic [7:0]        pushback_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0]      key_code;
    logic [KEYS-1:0] pressed_map;
    logic            none_pressed;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] first_repeat_delay;
    logic [CFG_W-1:0] repeat_interval;
    logic [CFG_W-1:0] release_hold;
  } cfg_t;

  // decoded command handed from front to back
  typedef struct packed {
    logic     scan;
    logic     get;
    logic     flush;
    logic     push;
    in_item_t item;
  } cmd_t;

  // wrapping signed difference test: (now - stamp) as int16 >= lim
  function automatic logic elapsed(input logic [TIME_W-1:0] now,
                                   input logic [TIME_W-1:0] stamp,
                                   input logic [CFG_W-1:0]  lim);
    logic [TIME_W-1:0] d;
    d = now - stamp;
    return !d[TIME_W-1] && (d[CFG_W-1:0] >= lim);
  endfunction

endpackage

[src/kars_front.sv]
module kars_front
  import kars_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     q_valid,
  output cmd_t     q_cmd,
  input  logic     q_pop
);

  // two-entry command queue
  cmd_t       q_mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       accept;
  cmd_t       cmd;

  assign in_stall = (cnt_r == 2'd2);
  assign accept   = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_mem_r[rd_ptr_r];

  // classify the op
  always_comb begin
    cmd.item  = in_data;
    cmd.scan  = (in_data.op == OP_SCAN);
    cmd.get   = (in_data.op == OP_GET);
    cmd.flush = (in_data.op == OP_FLUSH);
    cmd.push  = (in_data.op == OP_PUSH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, accept} - {1'b0, q_pop};
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !q_pop |=> q_valid)
    else $error("accepted beat missing from queue");

endmodule

[src/kars_back.sv]
module kars_back
  import kars_pkg::*;
#(
  parameter int FIFO_SLOTS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int PTR_W = (FIFO_SLOTS > 1) ? $clog2(FIFO_SLOTS) : 1;
  localparam int CNT_W = PTR_W;
  localparam int SUM_W = PTR_W + RANK_W + 1;
  localparam int CMP_W = ((RANK_W > CNT_W) ? RANK_W : CNT_W) + 1;

  // key state
  logic [KEYS-1:0]   pf_r, pf_nxt;
  logic [TIME_W-1:0] rpt_stamp_r [KEYS];
  logic [TIME_W-1:0] rpt_stamp_nxt [KEYS];
  logic [TIME_W-1:0] rel_stamp_r [KEYS];
  logic [TIME_W-1:0] rel_stamp_nxt [KEYS];

  // code FIFO
  logic [CODE_W-1:0] fifo_r [FIFO_SLOTS];
  logic [PTR_W-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [7:0]        pb_r, pb_nxt;

  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              fire;
  logic [KEYS-1:0]   want;
  logic [KEYS-1:0]   wr_en;
  logic [PTR_W-1:0]  wr_idx [KEYS];
  logic [RANK_W-1:0] rank;
  logic [CNT_W-1:0]  free_slots;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  wsum;
  logic [7:0]        code;
  logic [TIME_W-1:0] first_stamp;
  logic [PTR_W:0]    ptr_chk;

  assign fire      = q_valid && (!out_valid_r || !out_stall);
  assign q_pop     = fire;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign free_slots  = CNT_W'(FIFO_SLOTS - 1) - cnt_r;
  assign first_stamp = q_cmd.item.now_ms + TIME_W'(cfg.first_repeat_delay)
                       - TIME_W'(cfg.repeat_interval);

  // per-key scan lanes
  always_comb begin
    pf_nxt = pf_r;
    want   = '0;
    for (int i = 0; i < KEYS; i++) begin
      rpt_stamp_nxt[i] = rpt_stamp_r[i];
      rel_stamp_nxt[i] = rel_stamp_r[i];
      if (fire && q_cmd.scan) begin
        if (q_cmd.item.key_levels[i]) begin
          if (!pf_r[i]) begin
            rpt_stamp_nxt[i] = first_stamp;
            pf_nxt[i]        = 1'b1;
            want[i]          = 1'b1;
          end else if (elapsed(q_cmd.item.now_ms, rpt_stamp_r[i],
                               cfg.repeat_interval)) begin
            rpt_stamp_nxt[i] = q_cmd.item.now_ms;
            want[i]          = 1'b1;
          end
          rel_stamp_nxt[i] = q_cmd.item.now_ms;
        end else if (pf_r[i] && elapsed(q_cmd.item.now_ms, rel_stamp_r[i],
                                        cfg.release_hold)) begin
          pf_nxt[i] = 1'b0;
        end
      end
    end
  end

  // place queued codes: lower keys first, drop what does not fit
  always_comb begin
    rank = '0;
    for (int i = 0; i < KEYS; i++) begin
      wr_en[i] = want[i] && (CMP_W'(rank) < CMP_W'(free_slots));
      sum      = SUM_W'(wp_r) + SUM_W'(rank);
      if (sum >= SUM_W'(FIFO_SLOTS)) begin
        sum = sum - SUM_W'(FIFO_SLOTS);
      end
      wr_idx[i] = sum[PTR_W-1:0];
      if (wr_en[i]) begin
        rank = rank + RANK_W'(1);
      end
    end
    wsum = SUM_W'(wp_r) + SUM_W'(rank);
    if (wsum >= SUM_W'(FIFO_SLOTS)) begin
      wsum = wsum - SUM_W'(FIFO_SLOTS);
    end
  end

  // pointer, pushback slot, get and flush
  always_comb begin
    wp_nxt  = wsum[PTR_W-1:0];
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r + CNT_W'(rank);
    pb_nxt  = pb_r;
    code    = '0;
    if (fire) begin
      if (q_cmd.get) begin
        if (pb_r != 8'd0) begin
          code   = pb_r;
          pb_nxt = 8'd0;
        end else if (cnt_r != '0) begin
          code    = 8'(fifo_r[rp_r]);
          rp_nxt  = (rp_r == PTR_W'(FIFO_SLOTS - 1)) ? '0 : rp_r + PTR_W'(1);
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end else if (q_cmd.flush) begin
        rp_nxt  = wp_r;
        cnt_nxt = '0;
        pb_nxt  = 8'd0;
      end else if (q_cmd.push) begin
        pb_nxt = q_cmd.item.pushback_code;
      end
    end
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pf_r        <= '0;
      wp_r        <= '0;
      rp_r        <= '0;
      cnt_r       <= '0;
      pb_r        <= 8'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < KEYS; i++) begin
        rpt_stamp_r[i] <= '0;
        rel_stamp_r[i] <= '0;
      end
    end else begin
      pf_r  <= pf_nxt;
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
      pb_r  <= pb_nxt;
      for (int i = 0; i < KEYS; i++) begin
        rpt_stamp_r[i] <= rpt_stamp_nxt[i];
        rel_stamp_r[i] <= rel_stamp_nxt[i];
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: FIFO slots and result beat
  always_ff @(posedge clk) begin
    for (int i = 0; i < KEYS; i++) begin
      if (wr_en[i]) begin
        fifo_r[wr_idx[i]] <= CODE_W'(i + 1);
      end
    end
    if (fire) begin
      out_data_r.key_code     <= code;
      out_data_r.pressed_map  <= pf_nxt;
      out_data_r.none_pressed <= ~|pf_nxt;
    end
  end

  // write pointer must sit count slots past read pointer
  always_comb begin
    ptr_chk = (PTR_W+1)'(rp_r) + (PTR_W+1)'(cnt_r);
    if (ptr_chk >= (PTR_W+1)'(FIFO_SLOTS)) begin
      ptr_chk = ptr_chk - (PTR_W+1)'(FIFO_SLOTS);
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FIFO_SLOTS - 1))
    else $error("code FIFO overfilled");

  a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r == ptr_chk[PTR_W-1:0])
    else $error("FIFO pointers disagree with count");

  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    fire && q_cmd.flush |=> (cnt_r == '0) && (pb_r == 8'd0))
    else $error("flush left codes behind");

  a_pb_get_keeps_fifo: assert property (@(posedge clk) disable iff (!rst_n)
    fire && q_cmd.get && (pb_r != 8'd0) |=> $stable(cnt_r) && $stable(rp_r))
    else $error("pushback get touched FIFO");

endmodule

[src/key_autorepeat_scanner_fifo.sv]
// channel | ports                              | beat
// in      | in_valid, in_stall, in_data        | op, key_levels, now_ms, pushback_code
// out     | out_valid, out_stall, out_data     | key_code, pressed_map, none_pressed
// cfg     | cfg_we, cfg_index, cfg_wdata       | one register write, no read-back
//
// One item per cycle while out_stall is low; each in beat yields one registered out beat.
// The per-key scan lanes and the code FIFO update in the same cycle in the back end.
// A two-entry command queue separates input acceptance from execution.
// Synchronous active-low reset; no clearing pass, the FIFO slots need no reset.
// out_stall holds the result register; input keeps flowing until the queue fills.
module key_autorepeat_scanner_fifo
  import kars_pkg::*;
#(
  parameter int FIFO_SLOTS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t cfg_r;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_repeat_delay <= FIRST_DELAY_RST;
      cfg_r.repeat_interval    <= REPEAT_IVL_RST;
      cfg_r.release_hold       <= RELEASE_HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_DELAY:  cfg_r.first_repeat_delay <= cfg_wdata;
        CFG_REPEAT_IVL:   cfg_r.repeat_interval    <= cfg_wdata;
        CFG_RELEASE_HOLD: cfg_r.release_hold       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  kars_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  kars_back #(
    .FIFO_SLOTS (FIFO_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
